### sv/mseu_pkg.sv
// Package: word types, operation and error codes for the execute unit.
`timescale 1ns / 1ps

package mseu_pkg;

  localparam int DATA_WORDS_DEF = 4096;
  localparam int REG_COUNT      = 32;

  // operation codes
  localparam logic [4:0] FN_NOP   = 5'd0;
  localparam logic [4:0] FN_LI    = 5'd1;
  localparam logic [4:0] FN_MOVE  = 5'd2;
  localparam logic [4:0] FN_ADD   = 5'd3;
  localparam logic [4:0] FN_ADDU  = 5'd4;
  localparam logic [4:0] FN_SUB   = 5'd5;
  localparam logic [4:0] FN_MUL   = 5'd6;
  localparam logic [4:0] FN_ADDI  = 5'd7;
  localparam logic [4:0] FN_ADDIU = 5'd8;
  localparam logic [4:0] FN_AND   = 5'd9;
  localparam logic [4:0] FN_OR    = 5'd10;
  localparam logic [4:0] FN_XOR   = 5'd11;
  localparam logic [4:0] FN_SLL   = 5'd12;
  localparam logic [4:0] FN_SRL   = 5'd13;
  localparam logic [4:0] FN_SLT   = 5'd14;
  localparam logic [4:0] FN_LW    = 5'd15;
  localparam logic [4:0] FN_SW    = 5'd16;
  localparam logic [4:0] FN_BEQ   = 5'd17;
  localparam logic [4:0] FN_BNE   = 5'd18;
  localparam logic [4:0] FN_J     = 5'd19;
  localparam logic [4:0] FN_JAL   = 5'd20;
  localparam logic [4:0] FN_JR    = 5'd21;

  // error codes
  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_ADD_OVF = 3'd1;
  localparam logic [2:0] ERR_SUB_OVF = 3'd2;
  localparam logic [2:0] ERR_ALIGN   = 3'd3;
  localparam logic [2:0] ERR_OPCODE  = 3'd4;

  localparam logic [4:0] RA_IDX = 5'd31;

  typedef struct packed {
    logic [4:0]         func;
    logic [4:0]         dest_reg;
    logic [4:0]         src_a_reg;
    logic [4:0]         src_b_reg;
    logic signed [31:0] immediate;
    logic [31:0]        target;
  } in_word_t;

  typedef struct packed {
    logic [31:0]        next_pc;
    logic               reg_write;
    logic [4:0]         write_index;
    logic signed [31:0] write_value;
    logic [2:0]         error;
    logic               halted;
  } out_word_t;

endpackage

### sv/mips_subset_execute_unit_core.sv
// Execute unit: register file, data memory, program counter and one-pass ALU.
`timescale 1ns / 1ps

//  channel | ports                          | word / notes
//  --------+--------------------------------+---------------------------------------
//  input   | in_valid, in_stall, in_data    | in_word_t, one decoded instruction
//  result  | out_valid, out_stall, out_data | out_word_t, one per instruction
//  config  | cfg_wr_en, cfg_wr_data         | program_length, written any cycle
//
// One instruction per cycle sustained while in_stall stays low (no memory sweep and no stalled
// result). Accept registers the word and reads the register file; the operand register then
// feeds the ALU, the memory address and the data memory access, into the result register.
// After reset the data memory is swept to zero, every word in turn, with in_stall high.
// A stalled result holds the result register; one more word waits in the operand
// register before in_stall rises.

module mips_subset_execute_unit_core
  import mseu_pkg::*;
#(
  parameter int DATA_WORDS = DATA_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_data,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  localparam int AW   = $clog2(DATA_WORDS);
  localparam bit POW2 = (DATA_WORDS & (DATA_WORDS - 1)) == 0;
  // reciprocal for the word index remainder: exact floor for 30-bit indexes
  localparam int      KSH   = 30 + AW;
  localparam longint  RECIP = ((64'd1 << KSH) + 64'(DATA_WORDS) - 64'd1) / 64'(DATA_WORDS);

  // ---------------- control / state registers ----------------
  logic              clr_busy_r;
  logic [AW-1:0]     clr_cnt_r;
  logic              a_vld_r;
  logic              out_vld_r;
  logic              b_wr_r;
  logic              wb_pend_r;
  logic [31:0]       pc_r;
  logic [15:0]       prog_len_r;
  logic [REG_COUNT-1:0] rf_vld_r;

  // payload registers
  in_word_t          a_in_r;
  logic [31:0]       a_rd_r;
  logic [31:0]       b_rd_r;
  out_word_t         b_res_r;
  logic              b_load_r;
  logic [31:0]       mem_rdata_r;

  logic [31:0]       rf [REG_COUNT];
  logic [31:0]       dmem [DATA_WORDS];

  logic              b_free;
  logic              a_adv;
  logic              accept;

  logic [31:0]       wb_val;
  logic [31:0]       rd_a;
  logic [31:0]       rd_b;
  logic [31:0]       a_op;
  logic [31:0]       b_op;

  out_word_t         ex_res;
  logic              ld_go;
  logic              st_go;
  logic [31:0]       addr;
  logic [29:0]       widx;
  logic [AW-1:0]     mem_idx;

  // ---------------- handshake ----------------
  assign b_free    = !out_vld_r || !out_stall;
  assign a_adv     = a_vld_r && b_free;
  assign in_stall  = clr_busy_r || (a_vld_r && !b_free);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_vld_r;

  always_comb begin
    out_data = b_res_r;
    if (b_load_r) begin
      out_data.write_value = mem_rdata_r;
    end
  end

  // newest executed instruction's write, also the pending writeback data
  assign wb_val = out_data.write_value;

  // ---------------- register file read at accept ----------------
  always_comb begin
    if (wb_pend_r && b_res_r.write_index == in_data.src_a_reg) begin
      rd_a = wb_val;
    end else if (rf_vld_r[in_data.src_a_reg]) begin
      rd_a = rf[in_data.src_a_reg];
    end else begin
      rd_a = '0;
    end
    if (wb_pend_r && b_res_r.write_index == in_data.src_b_reg) begin
      rd_b = wb_val;
    end else if (rf_vld_r[in_data.src_b_reg]) begin
      rd_b = rf[in_data.src_b_reg];
    end else begin
      rd_b = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_in_r <= in_data;
      a_rd_r <= rd_a;
      b_rd_r <= rd_b;
    end
    if (wb_pend_r) begin
      rf[b_res_r.write_index] <= wb_val;
    end
  end

  // bypass from the result stage; register zero never sets b_wr_r
  assign a_op = (b_wr_r && b_res_r.write_index == a_in_r.src_a_reg) ? wb_val : a_rd_r;
  assign b_op = (b_wr_r && b_res_r.write_index == a_in_r.src_b_reg) ? wb_val : b_rd_r;

  // ---------------- memory word index ----------------
  assign addr = a_op + 32'(a_in_r.immediate);
  assign widx = addr[31:2];

  generate
    if (POW2) begin : g_idx_mask
      assign mem_idx = widx[AW-1:0];
    end else begin : g_idx_recip
      logic [60:0] prod;
      logic [29:0] quot;
      logic [29:0] rem;
      assign prod    = {31'b0, widx} * {30'b0, 31'(RECIP)};
      assign quot    = 30'(prod >> KSH);
      assign rem     = widx - 30'(quot * 30'(DATA_WORDS));
      assign mem_idx = rem[AW-1:0];
    end
  endgenerate

  // ---------------- execute ----------------
  always_comb begin
    logic [31:0] imm_u;
    logic [31:0] imm16;
    logic [31:0] sum_ab;
    logic [31:0] diff_ab;
    logic [31:0] sum_ai;
    logic [31:0] value;
    logic [31:0] nxt;
    logic [4:0]  dest;
    logic [2:0]  err;
    logic        wr;
    logic        is_ld;
    logic        is_st;
    logic        halt;

    imm_u   = 32'(a_in_r.immediate);
    imm16   = {{16{imm_u[15]}}, imm_u[15:0]};
    sum_ab  = a_op + b_op;
    diff_ab = a_op - b_op;
    sum_ai  = a_op + imm16;
    value   = '0;
    nxt     = pc_r + 32'd1;
    dest    = a_in_r.dest_reg;
    err     = ERR_NONE;
    wr      = 1'b0;
    is_ld   = 1'b0;
    is_st   = 1'b0;
    halt    = pc_r >= {16'b0, prog_len_r};

    case (a_in_r.func)
      FN_NOP: ;
      FN_LI: begin
        value = imm_u;
        wr    = 1'b1;
      end
      FN_MOVE: begin
        value = a_op;
        wr    = 1'b1;
      end
      FN_ADD: begin
        value = sum_ab;
        if (((a_op ^ sum_ab) & (b_op ^ sum_ab)) >> 31 != 32'd0) err = ERR_ADD_OVF;
        else wr = 1'b1;
      end
      FN_ADDU: begin
        value = sum_ab;
        wr    = 1'b1;
      end
      FN_SUB: begin
        value = diff_ab;
        if (((a_op ^ b_op) & (a_op ^ diff_ab)) >> 31 != 32'd0) err = ERR_SUB_OVF;
        else wr = 1'b1;
      end
      FN_MUL: begin
        value = a_op * b_op;
        wr    = 1'b1;
      end
      FN_ADDI: begin
        value = sum_ai;
        if (((a_op ^ sum_ai) & (imm16 ^ sum_ai)) >> 31 != 32'd0) err = ERR_ADD_OVF;
        else wr = 1'b1;
      end
      FN_ADDIU: begin
        value = sum_ai;
        wr    = 1'b1;
      end
      FN_AND: begin
        value = a_op & b_op;
        wr    = 1'b1;
      end
      FN_OR: begin
        value = a_op | b_op;
        wr    = 1'b1;
      end
      FN_XOR: begin
        value = a_op ^ b_op;
        wr    = 1'b1;
      end
      FN_SLL: begin
        value = a_op << imm_u[4:0];
        wr    = 1'b1;
      end
      FN_SRL: begin
        value = a_op >> imm_u[4:0];
        wr    = 1'b1;
      end
      FN_SLT: begin
        value = {31'b0, $signed(a_op) < $signed(b_op)};
        wr    = 1'b1;
      end
      FN_LW: begin
        if (addr[1:0] != 2'b00) err = ERR_ALIGN;
        else begin
          is_ld = 1'b1;
          wr    = 1'b1;
        end
      end
      FN_SW: begin
        if (addr[1:0] != 2'b00) err = ERR_ALIGN;
        else is_st = 1'b1;
      end
      FN_BEQ: begin
        if (a_op == b_op) nxt = a_in_r.target;
      end
      FN_BNE: begin
        if (a_op != b_op) nxt = a_in_r.target;
      end
      FN_J: nxt = a_in_r.target;
      FN_JAL: begin
        value = nxt;
        dest  = RA_IDX;
        wr    = 1'b1;
        nxt   = a_in_r.target;
      end
      FN_JR: nxt = a_op;
      default: err = ERR_OPCODE;
    endcase

    ex_res = '0;
    ld_go  = 1'b0;
    st_go  = 1'b0;
    if (halt) begin
      ex_res.next_pc = pc_r;
      ex_res.halted  = 1'b1;
    end else if (err != ERR_NONE) begin
      ex_res.next_pc = pc_r;
      ex_res.error   = err;
    end else begin
      ex_res.next_pc = nxt;
      st_go          = is_st;
      ld_go          = is_ld;
      if (wr && dest != 5'd0) begin
        ex_res.reg_write   = 1'b1;
        ex_res.write_index = dest;
        ex_res.write_value = value;
      end
    end
  end

  // ---------------- data memory ----------------
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      dmem[clr_cnt_r] <= '0;
    end else if (a_adv && st_go) begin
      dmem[mem_idx] <= b_op;
    end
    if (a_adv && ld_go) begin
      mem_rdata_r <= dmem[mem_idx];
    end
  end

  // ---------------- result register payload ----------------
  always_ff @(posedge clk) begin
    if (a_adv) begin
      b_res_r  <= ex_res;
      b_load_r <= ld_go && ex_res.reg_write;
    end
  end

  // ---------------- control state ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
      a_vld_r    <= 1'b0;
      out_vld_r  <= 1'b0;
      b_wr_r     <= 1'b0;
      wb_pend_r  <= 1'b0;
      pc_r       <= '0;
      prog_len_r <= '0;
      rf_vld_r   <= '0;
    end else begin
      if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == AW'(DATA_WORDS - 1)) clr_busy_r <= 1'b0;
      end
      if (cfg_wr_en) prog_len_r <= cfg_wr_data;

      if (accept) a_vld_r <= 1'b1;
      else if (a_adv) a_vld_r <= 1'b0;

      if (a_adv) out_vld_r <= 1'b1;
      else if (!out_stall) out_vld_r <= 1'b0;

      if (a_adv) begin
        b_wr_r <= ex_res.reg_write;
        pc_r   <= ex_res.next_pc;
      end
      wb_pend_r <= a_adv && ex_res.reg_write;
      if (wb_pend_r) rf_vld_r[b_res_r.write_index] <= 1'b1;
    end
  end

endmodule

### verif/mips_subset_execute_unit_core_tb.sv
// Testbench: runs decoded instructions through the execute unit and checks each result word.
`timescale 1ns / 1ps

module mips_subset_execute_unit_core_tb;
  import mseu_pkg::*;

  localparam int          MEM_WORDS    = DATA_WORDS_DEF;
  localparam int          QUIET_LIMIT  = 20000;  // covers the memory sweep after reset
  localparam int          HOLD_CYCLES  = 300;
  localparam logic [31:0] JUMP_SPAN    = 32'd2048;
  localparam logic [4:0]  FN_UNUSED_LO = 5'd22;
  localparam logic [4:0]  FN_UNUSED_HI = 5'd31;

  typedef struct {
    in_word_t  w;
    bit        typed;
    out_word_t exp;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_word_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_word_t   out_data;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  // mirror of the architectural state
  logic [31:0] gpr [REG_COUNT];
  logic [31:0] dmem [MEM_WORDS];
  logic [31:0] pc_q;
  logic [15:0] prog_len;

  out_word_t   result_q [$];
  dir_row_t    dir_rows [$];
  bit          typed_row;
  out_word_t   typed_exp;
  int          send_gap_pct;
  int          recv_stall_pct;
  bit          hold_req;
  int          hold_left;
  int          quiet_cycles;
  int          fail_cnt;

  mips_subset_execute_unit_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #4 clk = ~clk;

  function automatic in_word_t op(logic [4:0] f, logic [4:0] d, logic [4:0] sa,
                                  logic [4:0] sb, logic [31:0] imm, logic [31:0] tgt);
    return '{f, d, sa, sb, imm, tgt};
  endfunction

  function automatic out_word_t res(logic [31:0] npc, logic rw, logic [4:0] idx,
                                    logic [31:0] val, logic [2:0] err, logic halt);
    return '{npc, rw, idx, val, err, halt};
  endfunction

  function automatic void row(in_word_t w);
    dir_rows.push_back('{w, 1'b0, out_word_t'('0)});
  endfunction

  function automatic void row_exp(in_word_t w, out_word_t e);
    dir_rows.push_back('{w, 1'b1, e});
  endfunction

  // Executes one instruction against the mirrored state and returns its result word.
  function automatic out_word_t execute_insn(in_word_t w);
    out_word_t   r;
    logic [31:0] a, b, imm, imm16, val, addr, nxt, ovf;
    logic [2:0]  err;
    logic        wr;
    logic [4:0]  dst;
    r     = '0;
    a     = gpr[w.src_a_reg];
    b     = gpr[w.src_b_reg];
    imm   = w.immediate;
    imm16 = {{16{imm[15]}}, imm[15:0]};
    addr  = a + imm;
    nxt   = pc_q + 32'd1;
    val   = '0;
    err   = ERR_NONE;
    wr    = 1'b0;
    dst   = w.dest_reg;
    if (pc_q >= {16'd0, prog_len}) begin
      r.next_pc = pc_q;
      r.halted  = 1'b1;
      return r;
    end
    case (w.func)
      FN_NOP: ;
      FN_LI: begin val = imm; wr = 1'b1; end
      FN_MOVE: begin val = a; wr = 1'b1; end
      FN_ADD: begin
        val = a + b;
        ovf = (a ^ val) & (b ^ val);
        if (ovf[31]) err = ERR_ADD_OVF; else wr = 1'b1;
      end
      FN_ADDU: begin val = a + b; wr = 1'b1; end
      FN_SUB: begin
        val = a - b;
        ovf = (a ^ b) & (a ^ val);
        if (ovf[31]) err = ERR_SUB_OVF; else wr = 1'b1;
      end
      FN_MUL: begin val = a * b; wr = 1'b1; end
      FN_ADDI: begin
        val = a + imm16;
        ovf = (a ^ val) & (imm16 ^ val);
        if (ovf[31]) err = ERR_ADD_OVF; else wr = 1'b1;
      end
      FN_ADDIU: begin val = a + imm16; wr = 1'b1; end
      FN_AND: begin val = a & b; wr = 1'b1; end
      FN_OR: begin val = a | b; wr = 1'b1; end
      FN_XOR: begin val = a ^ b; wr = 1'b1; end
      FN_SLL: begin val = a << imm[4:0]; wr = 1'b1; end
      FN_SRL: begin val = a >> imm[4:0]; wr = 1'b1; end
      FN_SLT: begin val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0; wr = 1'b1; end
      FN_LW: begin
        if (addr[1:0] != 2'b00) begin
          err = ERR_ALIGN;
        end else begin
          val = dmem[(addr >> 2) % MEM_WORDS];
          wr  = 1'b1;
        end
      end
      FN_SW: begin
        if (addr[1:0] != 2'b00) err = ERR_ALIGN;
        else dmem[(addr >> 2) % MEM_WORDS] = b;
      end
      FN_BEQ: if (a == b) nxt = w.target;
      FN_BNE: if (a != b) nxt = w.target;
      FN_J: nxt = w.target;
      FN_JAL: begin
        val = nxt;
        dst = RA_IDX;
        wr  = 1'b1;
        nxt = w.target;
      end
      FN_JR: nxt = a;
      default: err = ERR_OPCODE;
    endcase
    if (err != ERR_NONE) begin
      r.next_pc = pc_q;
      r.error   = err;
      return r;
    end
    if (wr && dst != 5'd0) begin
      gpr[dst]      = val;
      r.reg_write   = 1'b1;
      r.write_index = dst;
      r.write_value = val;
    end
    pc_q      = nxt;
    r.next_pc = nxt;
    return r;
  endfunction

  // Mostly well-formed: loads and stores near a small window, jumps that land below JUMP_SPAN.
  function automatic in_word_t next_random_insn();
    in_word_t    w;
    logic [31:0] av, addr;
    logic [4:0]  r;
    int          sel;
    w.dest_reg  = 5'($urandom);
    w.src_a_reg = 5'($urandom);
    w.src_b_reg = 5'($urandom);
    w.immediate = $urandom;
    w.target    = $urandom;
    sel = $urandom_range(99);
    if (sel < 20) w.func = FN_LI;
    else if (sel < 25) w.func = 5'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));
    else if (sel < 40) w.func = $urandom_range(1) ? FN_LW : FN_SW;
    else w.func = 5'($urandom_range(FN_NOP, FN_JR));
    av = gpr[w.src_a_reg];
    case (w.func)
      FN_LI, FN_ADDI, FN_ADDIU:
        case ($urandom_range(4))
          0: w.immediate = 32'h7FFF_FFFF;
          1: w.immediate = 32'h8000_0000;
          2: w.immediate = 32'($urandom_range(255)) - 32'd128;
          default: ;
        endcase
      FN_LW, FN_SW: begin
        sel  = $urandom_range(9);
        addr = (sel < 3) ? ($urandom & ~32'd3) : (32'($urandom_range(63)) << 2);
        if (sel != 0) w.immediate = addr - av;  // otherwise keep a raw, often unaligned offset
      end
      FN_BEQ, FN_BNE: begin
        if ($urandom_range(2) == 0) w.src_b_reg = w.src_a_reg;
        // taken branches land below JUMP_SPAN, untaken ones carry any target
        if ((w.func == FN_BEQ) == (av == gpr[w.src_b_reg]))
          w.target = $urandom_range(JUMP_SPAN - 1);
      end
      FN_J, FN_JAL: w.target = $urandom_range(JUMP_SPAN - 1);
      FN_JR: begin
        sel         = $urandom_range(31);
        w.src_a_reg = 5'd0;
        for (int k = 0; k < REG_COUNT; k++) begin
          r = 5'(sel + k);
          if (gpr[r] < JUMP_SPAN) begin
            w.src_a_reg = r;
            break;
          end
        end
      end
      default: ;
    endcase
    return w;
  endfunction

  function automatic void flag_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      fail_cnt++;
    end
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic drive_word(input in_word_t w, input bit typed, input out_word_t e);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_data   <= w;
    typed_row = typed;
    typed_exp = e;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic run_burst(input int n, input int gap, input int stall);
    send_gap_pct   = gap;
    recv_stall_pct = stall;
    repeat (n) drive_word(next_random_insn(), 1'b0, out_word_t'('0));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (result_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_prog_len(input logic [15:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    prog_len  = v;
  endtask

  // receiver: random stalls plus an occasional long hold-off
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
    if (hold_left != 0) hold_left--;
  end

  // accepted instruction words feed the predictor; watchdog on handshake activity
  always @(posedge clk) begin
    out_word_t pred;
    if (rst_n && in_valid && !in_stall) begin
      pred = execute_insn(in_data);
      result_q.push_back(typed_row ? typed_exp : pred);
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("mips_subset_execute_unit_core test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (result_q.size() == 0) begin
        $error("result word with nothing expected: next_pc %h", out_data.next_pc);
        fail_cnt++;
      end else begin
        want = result_q.pop_front();
        flag_field("next_pc", want.next_pc, out_data.next_pc);
        flag_field("reg_write", 32'(want.reg_write), 32'(out_data.reg_write));
        flag_field("write_index", 32'(want.write_index), 32'(out_data.write_index));
        flag_field("write_value", want.write_value, out_data.write_value);
        flag_field("error", 32'(want.error), 32'(out_data.error));
        flag_field("halted", 32'(want.halted), 32'(out_data.halted));
      end
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_stall      = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    typed_row      = 1'b0;
    typed_exp      = '0;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b0;
    hold_left      = 0;
    quiet_cycles   = 0;
    fail_cnt       = 0;
    pc_q           = '0;
    prog_len       = '0;
    foreach (gpr[i]) gpr[i] = '0;
    foreach (dmem[i]) dmem[i] = '0;

    // program length still zero: halt wins over a bad opcode
    row_exp(op(FN_UNUSED_HI, 31, 31, 31, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
            res(0, 0, 0, 0, ERR_NONE, 1));
    // the rest runs with the longest program
    row_exp(op(FN_LI, 1, 0, 0, 32'h7FFF_FFFF, 0), res(1, 1, 1, 32'h7FFF_FFFF, ERR_NONE, 0));
    row_exp(op(FN_LI, 2, 0, 0, 32'h8000_0000, 0), res(2, 1, 2, 32'h8000_0000, ERR_NONE, 0));
    row_exp(op(FN_LI, 0, 0, 0, 32'hFFFF_FFFF, 0), res(3, 0, 0, 0, ERR_NONE, 0));
    row_exp(op(FN_ADD, 3, 1, 1, 0, 0), res(3, 0, 0, 0, ERR_ADD_OVF, 0));
    row_exp(op(FN_SUB, 3, 2, 1, 0, 0), res(3, 0, 0, 0, ERR_SUB_OVF, 0));
    row_exp(op(FN_ADDI, 3, 1, 0, 1, 0), res(3, 0, 0, 0, ERR_ADD_OVF, 0));
    row(op(FN_ADDU, 3, 1, 1, 0, 0));
    row(op(FN_ADDIU, 4, 2, 0, 32'hFFFF_8000, 0));
    row(op(FN_MUL, 5, 1, 2, 0, 0));
    row(op(FN_AND, 6, 1, 3, 0, 0));
    row(op(FN_OR, 7, 2, 3, 0, 0));
    row(op(FN_XOR, 8, 1, 2, 0, 0));
    row(op(FN_SLL, 9, 1, 0, 32'hFFFF_FFFF, 0));
    row(op(FN_SRL, 10, 2, 0, 32'hFFFF_FFFF, 0));
    row(op(FN_SLT, 11, 2, 1, 0, 0));
    row(op(FN_SW, 0, 0, 1, 32'h0000_7FFC, 0));
    row(op(FN_LW, 12, 0, 0, 32'hFFFF_FFFC, 0));  // wraps onto the word just stored
    row_exp(op(FN_LW, 12, 0, 0, 2, 0), res(14, 0, 0, 0, ERR_ALIGN, 0));
    row_exp(op(FN_SW, 0, 0, 1, 1, 0), res(14, 0, 0, 0, ERR_ALIGN, 0));
    row(op(FN_MOVE, 13, 1, 0, 0, 0));
    row(op(FN_BEQ, 0, 0, 0, 0, 20));
    row(op(FN_BNE, 0, 0, 0, 0, 32'hFFFF_FFFF));
    row(op(FN_JAL, 5, 0, 0, 0, 30));  // link goes to $ra whatever dest says
    row(op(FN_JR, 0, 31, 0, 0, 0));
    row(op(FN_J, 0, 0, 0, 0, 40));
    row(op(FN_NOP, 0, 0, 0, 0, 0));
    row_exp(op(FN_UNUSED_LO, 1, 1, 1, 0, 0), res(41, 0, 0, 0, ERR_OPCODE, 0));

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < dir_rows.size(); i++) begin
      if (i == 1) begin
        drain();
        set_prog_len(16'hFFFF);
      end
      drive_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].exp);
    end

    run_burst(450, 0, 0);
    drain();
    set_prog_len(pc_q[15:0]);  // pc sits exactly at the end
    run_burst(25, 85, 0);
    drain();
    set_prog_len(pc_q[15:0] + 16'($urandom_range(100, 400)));
    run_burst(450, 0, 85);
    drain();
    set_prog_len(16'hFFFF);
    hold_req = 1'b1;
    run_burst(450, 18, 18);
    run_burst(425, 85, 0);

    // jump through a register to the top of the address space, then stay halted
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    drive_word(op(FN_LI, 12, 0, 0, 32'hFFFF_FFFF, 0), 1'b0, out_word_t'('0));
    drive_word(op(FN_JR, 0, 12, 0, 0, 0), 1'b0, out_word_t'('0));
    drive_word(op(FN_NOP, 0, 0, 0, 0, 0), 1'b0, out_word_t'('0));
    drain();

    if (fail_cnt == 0) $display("mips_subset_execute_unit_core test passed");
    else $display("mips_subset_execute_unit_core test failed");
    $finish;
  end

endmodule

### files.f
sv/mseu_pkg.sv
sv/mips_subset_execute_unit_core.sv
verif/mips_subset_execute_unit_core_tb.sv
